// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/rpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpp_pkg
// widths, fixed-point constants and types of the rotate and project pipeline
// ----------------------------------------------------------------------------
package rpp_pkg;

  // field widths
  localparam int ANG_W    = 16;
  localparam int COORD_W  = 32;
  localparam int CENTRE_W = 16;
  localparam int GAIN_W   = 32;
  localparam int RES_W    = 32;

  // config port
  localparam int CFG_W = 2;
  localparam int DATA_W = 32;
  localparam logic [CFG_W-1:0] CFG_CENTRE_U = 2'd0;
  localparam logic [CFG_W-1:0] CFG_CENTRE_V = 2'd1;
  localparam logic [CFG_W-1:0] CFG_GAIN_U   = 2'd2;
  localparam logic [CFG_W-1:0] CFG_GAIN_V   = 2'd3;

  localparam logic [CENTRE_W-1:0] CENTRE_RESET = '0;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'h0001_0000;

  // angle path, Q.30
  localparam int ANG_SHIFT = 18;
  localparam int TH_W      = 36;
  localparam int CX_W      = 34;
  localparam int CZ_W      = 33;
  localparam int ATAN_W    = 30;
  localparam int ATAN_ENTRIES = 24;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [TH_W-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [TH_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [TH_W-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CX_W-1:0] Q30_INV_GAIN = 34'sd652032874;

  // truncated atan(2^-i) in Q.30
  localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  // projection path
  localparam int PROD_W    = CX_W + COORD_W;     // cos*y, sin*z
  localparam int W_W       = PROD_W + 1;         // their difference, Q.46
  localparam int MAG_W     = 63;                 // magnitude fed to the gain
  localparam int U_SHIFT   = 30;                 // x to Q.46
  localparam int LO_W      = 32;                 // split of the magnitude
  localparam int HI_W      = MAG_W - LO_W;
  localparam int P_W       = MAG_W + GAIN_W;     // magnitude times gain, Q.62
  localparam int T_W       = P_W + 2;            // signed, centre added
  localparam int FRAC_BITS = 62;
  localparam int WHOLE_W   = T_W - FRAC_BITS;

  // one cordic cell's worth of state, coordinates travel alongside
  typedef struct packed {
    logic                      flip;
    logic signed [CX_W-1:0]    cx;
    logic signed [CX_W-1:0]    cy;
    logic signed [CZ_W-1:0]    cz;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } rpp_cell_t;

endpackage

// ===== src/rpp_reduce.sv =====
// ----------------------------------------------------------------------------
// rpp_reduce
// takes the angle to Q.30, wraps it into [-pi, pi) and folds it into
// [-pi/2, pi/2], loading the first cordic cell
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpp_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [rpp_pkg::ANG_W-1:0]   angle_i,
  input  logic signed [rpp_pkg::COORD_W-1:0] x_i,
  input  logic signed [rpp_pkg::COORD_W-1:0] y_i,
  input  logic signed [rpp_pkg::COORD_W-1:0] z_i,
  output logic                              valid_o,
  output rpp_pkg::rpp_cell_t                cell_o
);
  import rpp_pkg::*;

  logic signed [TH_W-1:0] theta0;
  logic signed [TH_W-1:0] theta1;
  logic signed [TH_W-1:0] theta2;
  logic                   flip;
  rpp_cell_t              cell_d;
  rpp_cell_t              cell_q;
  logic                   valid_q;

  always_comb begin
    theta0 = {{(TH_W-ANG_W-ANG_SHIFT){angle_i[ANG_W-1]}}, angle_i, {ANG_SHIFT{1'b0}}};

    // one wrap is enough for the whole angle range
    if (theta0 >= Q30_PI) begin
      theta1 = theta0 - Q30_TWO_PI;
    end else if (theta0 < -Q30_PI) begin
      theta1 = theta0 + Q30_TWO_PI;
    end else begin
      theta1 = theta0;
    end

    // fold into the right half plane, sin and cos change sign
    if (theta1 > Q30_HALF_PI) begin
      theta2 = theta1 - Q30_PI;
      flip   = 1'b1;
    end else if (theta1 < -Q30_HALF_PI) begin
      theta2 = theta1 + Q30_PI;
      flip   = 1'b1;
    end else begin
      theta2 = theta1;
      flip   = 1'b0;
    end

    cell_d.flip = flip;
    cell_d.cx   = Q30_INV_GAIN;
    cell_d.cy   = '0;
    cell_d.cz   = theta2[CZ_W-1:0];
    cell_d.px   = x_i;
    cell_d.py   = y_i;
    cell_d.pz   = z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

  `ASSERT_RST(a_fold_range, clk_i, rst_ni,
    valid_q |-> ($signed(cell_q.cz) <= $signed(Q30_HALF_PI[CZ_W-1:0]) &&
                 $signed(cell_q.cz) >= -$signed(Q30_HALF_PI[CZ_W-1:0])))

endmodule

// ===== src/rpp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rpp_cordic_cell
// one rotation-mode cordic step, registered, steering the residual angle
// toward zero
// ----------------------------------------------------------------------------
module rpp_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rpp_pkg::rpp_cell_t cell_i,
  output logic               valid_o,
  output rpp_pkg::rpp_cell_t cell_o
);
  import rpp_pkg::*;

  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  logic signed [CZ_W-1:0] da;
  rpp_cell_t              cell_d;
  rpp_cell_t              cell_q;
  logic                   valid_q;

  always_comb begin
    // arithmetic shifts round toward minus infinity
    dx = $signed(cell_i.cy) >>> STAGE;
    dy = $signed(cell_i.cx) >>> STAGE;
    da = $signed({{(CZ_W-ATAN_W){1'b0}}, ATAN_Q30[STAGE]});
    cell_d = cell_i;
    // zero residual counts as positive
    if (!cell_i.cz[CZ_W-1]) begin
      cell_d.cx = cell_i.cx - dx;
      cell_d.cy = cell_i.cy + dy;
      cell_d.cz = cell_i.cz - da;
    end else begin
      cell_d.cx = cell_i.cx + dx;
      cell_d.cy = cell_i.cy - dy;
      cell_d.cz = cell_i.cz + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== src/rpp_project.sv =====
// ----------------------------------------------------------------------------
// rpp_project
// scales a signed Q.46 magnitude by a Q16.16 gain, adds the centre, rounds
// half to even and saturates to 32 bits
// ----------------------------------------------------------------------------
module rpp_project (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic                              neg_i,
  input  logic [rpp_pkg::MAG_W-1:0]          mag_i,
  input  logic [rpp_pkg::GAIN_W-1:0]         gain_i,
  input  logic [rpp_pkg::CENTRE_W-1:0]       centre_i,
  output logic signed [rpp_pkg::RES_W-1:0]   res_o
);
  import rpp_pkg::*;

  localparam logic signed [WHOLE_W:0] SAT_HI =
    {{(WHOLE_W+1-RES_W){1'b0}}, 1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [WHOLE_W:0] SAT_LO =
    {{(WHOLE_W+1-RES_W){1'b1}}, 1'b1, {(RES_W-1){1'b0}}};

  logic                      neg1_q;
  logic [MAG_W-1:0]          mag1_q;
  logic                      neg2_q;
  logic [LO_W+GAIN_W-1:0]    lo_q;
  logic [HI_W+GAIN_W-1:0]    hi_q;
  logic [P_W-1:0]            prod;
  logic [T_W-1:0]            centre_ext;
  logic [T_W-1:0]            t_d;
  logic [T_W-1:0]            t_q;
  logic signed [WHOLE_W-1:0] whole;
  logic                      up;
  logic signed [WHOLE_W:0]   rnd;

  // product split into two partial products, 32 bit by 32 bit and 31 bit by 32 bit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg_i;
      mag1_q <= mag_i;
      neg2_q <= neg1_q;
      lo_q   <= (LO_W+GAIN_W)'(mag1_q[LO_W-1:0]) * (LO_W+GAIN_W)'(gain_i);
      hi_q   <= (HI_W+GAIN_W)'(mag1_q[MAG_W-1:LO_W]) * (HI_W+GAIN_W)'(gain_i);
      t_q    <= t_d;
    end
  end

  always_comb begin
    prod       = P_W'({hi_q, {LO_W{1'b0}}}) + P_W'(lo_q);
    centre_ext = T_W'({centre_i, {FRAC_BITS{1'b0}}});
    t_d        = neg2_q ? (centre_ext - T_W'(prod)) : (centre_ext + T_W'(prod));
  end

  always_comb begin
    whole = $signed(t_q[T_W-1:FRAC_BITS]);
    // above half, or exactly half with an odd floor
    up    = t_q[FRAC_BITS-1] & ((|t_q[FRAC_BITS-2:0]) | whole[0]);
    rnd   = $signed({whole[WHOLE_W-1], whole}) + $signed({{WHOLE_W{1'b0}}, up});
    if (rnd > SAT_HI) begin
      res_o = SAT_HI[RES_W-1:0];
    end else if (rnd < SAT_LO) begin
      res_o = SAT_LO[RES_W-1:0];
    end else begin
      res_o = rnd[RES_W-1:0];
    end
  end

endmodule

// ===== src/rotate_project_point_top.sv =====
// ----------------------------------------------------------------------------
// rotate_project_point_top
// orthographic projection of a world point for a view rotated about x
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | sink      | in_valid_i / in_stall_o   | angle_i, x_i, y_i, z_i
//   out     | source    | out_valid_o / out_stall_i | u_o, v_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one transaction per cycle in and out while in_stall_o is low; the path runs
// through the reduce stage, the cordic cells, two multiply stages and rounding
// asynchronous active-low reset empties the pipeline and loads centre 0, gain 1.0
// a stalled output parks one result in a skid register, after which the whole
// pipeline freezes and in_stall_o rises until the skid drains
// configuration writes are always ready and take effect at once
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotate_project_point_top #(
  parameter int CORDIC_STAGES = rpp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [rpp_pkg::ANG_W-1:0]   angle_i,
  input  logic signed [rpp_pkg::COORD_W-1:0] x_i,
  input  logic signed [rpp_pkg::COORD_W-1:0] y_i,
  input  logic signed [rpp_pkg::COORD_W-1:0] z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rpp_pkg::RES_W-1:0]   u_o,
  output logic signed [rpp_pkg::RES_W-1:0]   v_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rpp_pkg::CFG_W-1:0]          cfg_index_i,
  input  logic [rpp_pkg::DATA_W-1:0]         cfg_data_i
);
  import rpp_pkg::*;

  localparam int POST_STAGES = 5;

  // configuration
  logic [CENTRE_W-1:0] centre_u_q, centre_v_q;
  logic [GAIN_W-1:0]   gain_u_q, gain_v_q;

  // pipeline control
  logic                   en;
  logic [POST_STAGES-1:0] post_v_q;

  // cordic row
  rpp_cell_t cell_s [CORDIC_STAGES+1];
  logic      cell_v [CORDIC_STAGES+1];

  // product stages
  logic signed [PROD_W-1:0]  prod_y_d, prod_z_d, prod_y_q, prod_z_q;
  logic [COORD_W-1:0]        magx_d, magx1_q, magx2_q;
  logic                      negx1_q, negx2_q, flip1_q, flip2_q;
  logic signed [W_W-1:0]     w_q;
  logic [W_W-1:0]            w_abs;
  logic                      neg_v;
  logic [MAG_W-1:0]          mag_u, mag_v;
  logic signed [RES_W-1:0]   res_u, res_v;
  logic                      res_valid;

  // output and skid
  logic                    out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic signed [RES_W-1:0] out_u_d, out_u_q, out_v_d, out_v_q;
  logic signed [RES_W-1:0] skid_u_d, skid_u_q, skid_v_d, skid_v_q;
  logic                    out_fire;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_u_q <= CENTRE_RESET;
      centre_v_q <= CENTRE_RESET;
      gain_u_q   <= GAIN_RESET;
      gain_v_q   <= GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CENTRE_U: centre_u_q <= cfg_data_i[CENTRE_W-1:0];
        CFG_CENTRE_V: centre_v_q <= cfg_data_i[CENTRE_W-1:0];
        CFG_GAIN_U:   gain_u_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_V:   gain_v_q   <= cfg_data_i[GAIN_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- angle
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  rpp_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (angle_i),
    .x_i     (x_i),
    .y_i     (y_i),
    .z_i     (z_i),
    .valid_o (cell_v[0]),
    .cell_o  (cell_s[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rpp_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_v[g]),
      .cell_i  (cell_s[g]),
      .valid_o (cell_v[g+1]),
      .cell_o  (cell_s[g+1])
    );
  end

  // ---------------------------------------------------------------- products
  always_comb begin
    prod_y_d = PROD_W'(cell_s[CORDIC_STAGES].cx) * PROD_W'(cell_s[CORDIC_STAGES].py);
    prod_z_d = PROD_W'(cell_s[CORDIC_STAGES].cy) * PROD_W'(cell_s[CORDIC_STAGES].pz);
    magx_d   = cell_s[CORDIC_STAGES].px[COORD_W-1] ?
               (COORD_W'(0) - COORD_W'(cell_s[CORDIC_STAGES].px)) :
               COORD_W'(cell_s[CORDIC_STAGES].px);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      magx1_q  <= magx_d;
      negx1_q  <= cell_s[CORDIC_STAGES].px[COORD_W-1];
      flip1_q  <= cell_s[CORDIC_STAGES].flip;
      w_q      <= W_W'(prod_y_q) - W_W'(prod_z_q);
      magx2_q  <= magx1_q;
      negx2_q  <= negx1_q;
      flip2_q  <= flip1_q;
    end
  end

  // the fold negates both sin and cos, so it only flips the sign of w
  always_comb begin
    w_abs = w_q[W_W-1] ? (W_W'(0) - W_W'(w_q)) : W_W'(w_q);
    mag_v = w_abs[MAG_W-1:0];
    neg_v = w_q[W_W-1] ^ flip2_q;
    mag_u = {{(MAG_W-COORD_W-U_SHIFT){1'b0}}, magx2_q, {U_SHIFT{1'b0}}};
  end

  rpp_project u_proj_u (
    .clk_i    (clk_i),
    .en_i     (en),
    .neg_i    (negx2_q),
    .mag_i    (mag_u),
    .gain_i   (gain_u_q),
    .centre_i (centre_u_q),
    .res_o    (res_u)
  );

  rpp_project u_proj_v (
    .clk_i    (clk_i),
    .en_i     (en),
    .neg_i    (neg_v),
    .mag_i    (mag_v),
    .gain_i   (gain_v_q),
    .centre_i (centre_v_q),
    .res_o    (res_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_v_q <= '0;
    end else if (en) begin
      post_v_q <= {post_v_q[POST_STAGES-2:0], cell_v[CORDIC_STAGES]};
    end
  end

  assign res_valid = post_v_q[POST_STAGES-1];

  // ---------------------------------------------------------------- output
  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_u_d      = out_u_q;
    out_v_d      = out_v_q;
    skid_u_d     = skid_u_q;
    skid_v_d     = skid_v_q;
    priority if (skid_valid_q) begin
      if (out_fire) begin
        out_u_d      = skid_u_q;
        out_v_d      = skid_v_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || !out_stall_i) begin
        out_u_d     = res_u;
        out_v_d     = res_v;
        out_valid_d = 1'b1;
      end else begin
        skid_u_d     = res_u;
        skid_v_d     = res_v;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_u_q  <= out_u_d;
    out_v_q  <= out_v_d;
    skid_u_q <= skid_u_d;
    skid_v_q <= skid_v_d;
  end

  assign out_valid_o = out_valid_q;
  assign u_o         = out_u_q;
  assign v_o         = out_v_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_RST(a_skid_behind_out, clk_i, rst_ni, !skid_valid_q || out_valid_q)

  `ASSERT_RST(a_skid_catches, clk_i, rst_ni,
    (res_valid && out_valid_q && out_stall_i && !skid_valid_q) |=> skid_valid_q)

  `ASSERT_RST(a_accept_enters, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> cell_v[0])

endmodule
